### rtl/delimiter_stream_splitter_unit_assert.svh
// Assertion macros for the delimiter stream splitter.
// No dependencies; the macros compile to nothing when SYNTHESIS is defined.
`ifndef DELIMITER_STREAM_SPLITTER_UNIT_ASSERT_SVH
`define DELIMITER_STREAM_SPLITTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define DSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("delimiter splitter assertion failed");
// Next-cycle implication, checked outside reset.
`define DSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("delimiter splitter assertion failed");
`else
`define DSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define DSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/dss_pkg.sv
// Package of the delimiter stream splitter: payload types and register indexes.
// No dependencies.
package dss_pkg;

	// Input transaction: one message byte.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} in_item_t;

	// Output transaction: one segment.
	typedef struct packed {
		logic [15:0] segment_start;
		logic [15:0] segment_length;
		logic        final_segment;
	} out_item_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_DELIMITER_BYTES  = 2'd0;
	localparam logic [1:0] REG_DELIMITER_LENGTH = 2'd1;
	localparam logic [1:0] REG_SEGMENT_LIMIT    = 2'd2;

	// Result queue depth; a power of two so the pointers wrap naturally.
	localparam int OUT_DEPTH = 4;

endpackage

### rtl/delimiter_stream_splitter_unit.sv
// Delimiter stream splitter: one message byte per input transaction, 0 to 2 segments out.
// Results are written into the result queue when their byte is accepted; one byte per cycle is
// taken while the four-entry result queue has room for two segments.
// Throughput is bounded by the output port: an item with two results needs two output transactions.
// Reset (arst_n low, asynchronous) clears message state, registers and the queue pointers and fill count.
// Depends on dss_pkg and delimiter_stream_splitter_unit_assert.svh.
`include "delimiter_stream_splitter_unit_assert.svh"

module delimiter_stream_splitter_unit
	import dss_pkg::*;
#(
	parameter int MAX_DELIMITER_BYTES = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  in_item_t                         in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output out_item_t                        out_data,
	input  logic                             write_en,
	input  logic [1:0]                       write_index,
	input  logic [63:0]                      write_data
);

	localparam int WIN_W = 8 * MAX_DELIMITER_BYTES;
	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);
	localparam logic [3:0] MAX_LEN = 4'(MAX_DELIMITER_BYTES);
	localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(OUT_DEPTH - 2);

	// Clamp a 17-bit position to 16 bits.
	function automatic logic [15:0] sat16(input logic [16:0] v);
		return v[16] ? 16'hFFFF : v[15:0];
	endfunction

	// Configuration registers.
	logic [WIN_W-1:0] delim_q;
	logic [3:0]       delim_len_q;
	logic [15:0]      seg_limit_q;

	// Message state.
	logic [WIN_W-1:0] recent_q;
	logic [15:0]      pos_q;
	logic [15:0]      seg_start_q;
	logic [15:0]      seg_count_q;
	logic             limit_q;

	// Result queue.
	out_item_t        queue_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic             in_acc;
	logic             out_acc;
	logic [WIN_W-1:0] window;
	logic [3:0]       len_used;
	logic             hit;
	logic [16:0]      end_pos;
	logic [16:0]      len_ext;
	logic [16:0]      match_start;
	logic             match;
	logic [15:0]      count_inc;
	logic             limit_hit;
	logic [15:0]      start_after;
	logic [16:0]      tail_len;
	logic             tail_en;
	out_item_t        res_match;
	out_item_t        res_tail;
	out_item_t        push_first;
	logic [1:0]       push_cnt;

	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;
	assign in_stall  = count_q > ROOM_LIMIT;
	assign out_valid = count_q != '0;
	assign out_data  = queue_q[rd_ptr_q];

	// Shift the new byte into the match window.
	generate
		if (MAX_DELIMITER_BYTES == 1) begin : g_win_one
			assign window = in_data.data_byte;
		end else begin : g_win_many
			assign window = {recent_q[WIN_W-9:0], in_data.data_byte};
		end
	endgenerate

	// Delimiter length in use: zero counts as one, large values are clamped.
	always_comb begin
		if (delim_len_q == 4'd0) begin
			len_used = 4'd1;
		end else if (delim_len_q > MAX_LEN) begin
			len_used = MAX_LEN;
		end else begin
			len_used = delim_len_q;
		end
	end

	// Parallel compare of the window against the pattern for every length.
	always_comb begin
		logic ok;
		hit = 1'b0;
		for (int l = 1; l <= MAX_DELIMITER_BYTES; l++) begin
			ok = 1'b1;
			for (int k = 0; k < l; k++) begin
				if (delim_q[8*k +: 8] != window[8*(l-1-k) +: 8]) begin
					ok = 1'b0;
				end
			end
			if (len_used == 4'(l)) begin
				hit = ok;
			end
		end
	end

	// Segment arithmetic for the match and for the tail.
	always_comb begin
		end_pos     = {1'b0, pos_q} + 17'd1;
		len_ext     = {13'd0, len_used};
		match_start = end_pos - len_ext;
		match       = hit && (end_pos >= len_ext) && (match_start >= {1'b0, seg_start_q});
		count_inc   = (seg_count_q != 16'hFFFF) ? seg_count_q + 16'd1 : seg_count_q;
		limit_hit   = match && (seg_limit_q != 16'd0) && (count_inc == seg_limit_q);
		start_after = match ? sat16(end_pos) : seg_start_q;
		tail_len    = (end_pos >= {1'b0, start_after}) ? end_pos - {1'b0, start_after} : 17'd0;
		tail_en     = in_data.end_of_message && !limit_hit;

		res_match.segment_start  = seg_start_q;
		res_match.segment_length = sat16(match_start - {1'b0, seg_start_q});
		res_match.final_segment  = limit_hit;
		res_tail.segment_start   = start_after;
		res_tail.segment_length  = sat16(tail_len);
		res_tail.final_segment   = 1'b1;

		push_first = match ? res_match : res_tail;
		if (!in_acc || limit_q) begin
			push_cnt = 2'd0;
		end else begin
			push_cnt = 2'(match) + 2'(tail_en);
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q     <= '0;
			delim_len_q <= 4'd1;
			seg_limit_q <= 16'd0;
		end else if (write_en) begin
			case (write_index)
				REG_DELIMITER_BYTES:  delim_q     <= write_data[WIN_W-1:0];
				REG_DELIMITER_LENGTH: delim_len_q <= write_data[3:0];
				REG_SEGMENT_LIMIT:    seg_limit_q <= write_data[15:0];
				default: ;
			endcase
		end
	end

	// Message state; the last byte returns everything to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q    <= '0;
			pos_q       <= 16'd0;
			seg_start_q <= 16'd0;
			seg_count_q <= 16'd0;
			limit_q     <= 1'b0;
		end else if (in_acc) begin
			if (in_data.end_of_message) begin
				recent_q    <= '0;
				pos_q       <= 16'd0;
				seg_start_q <= 16'd0;
				seg_count_q <= 16'd0;
				limit_q     <= 1'b0;
			end else if (!limit_q) begin
				recent_q    <= window;
				pos_q       <= sat16(end_pos);
				seg_start_q <= start_after;
				limit_q     <= limit_hit;
				if (match) begin
					seg_count_q <= count_inc;
				end
			end
		end
	end

	// Result queue payload.
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			queue_q[wr_ptr_q] <= push_first;
		end
		if (push_cnt == 2'd2) begin
			queue_q[wr_ptr_q + PTR_W'(1)] <= res_tail;
		end
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_cnt);
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push_cnt) - CNT_W'(out_acc);
		end
	end

	`DSS_ASSERT_NOW(a_queue_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(OUT_DEPTH))
	`DSS_ASSERT_NOW(a_start_behind_pos, clk, arst_n, 1'b1, seg_start_q <= pos_q)
	`DSS_ASSERT_NOW(a_two_only_at_end, clk, arst_n, push_cnt == 2'd2,
		in_data.end_of_message && match)
	`DSS_ASSERT_NOW(a_dropped_silent, clk, arst_n, limit_q, push_cnt == 2'd0)
	`DSS_ASSERT_NEXT(a_end_clears, clk, arst_n, in_acc && in_data.end_of_message,
		pos_q == 16'd0 && seg_count_q == 16'd0 && !limit_q)

endmodule

### dv/delimiter_stream_splitter_unit_checker.sv
// Checker for the delimiter stream splitter: watches both channels and the register port.
// It predicts the segments of every accepted byte and compares them with the output.
// Depends on dss_pkg.
`timescale 1ns / 100ps

module delimiter_stream_splitter_unit_checker
	import dss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_item_t    in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_item_t   out_data,
	input  logic        write_en,
	input  logic [1:0]  write_index,
	input  logic [63:0] write_data,
	output int          fail_count,
	output int          pending
);

	localparam int WINDOW_BYTES = 8;

	// Register copies.
	logic [63:0] cfg_pattern;
	logic [3:0]  cfg_length;
	logic [15:0] cfg_limit;

	// Message state of the predictor.
	logic [63:0] recent;
	logic [15:0] position;
	logic [15:0] seg_start;
	logic [15:0] seg_count;
	logic        stopped;

	// Segments predicted but not yet seen on the output.
	out_item_t expected_segments[$];

	function automatic logic [15:0] clamp16(input logic [16:0] v);
		return v[16] ? 16'hFFFF : v[15:0];
	endfunction

	task automatic clear_message();
		recent    = '0;
		position  = '0;
		seg_start = '0;
		seg_count = '0;
		stopped   = 1'b0;
	endtask

	// Advance the message state by one byte and queue the segments it closes.
	task automatic predict_segments(input in_item_t item);
		int unsigned len;
		logic [16:0] end_pos;
		logic        hit;
		out_item_t   seg;
		if (!stopped) begin
			if (cfg_length == 4'd0)
				len = 1;
			else if (cfg_length > 4'(WINDOW_BYTES))
				len = WINDOW_BYTES;
			else
				len = cfg_length;
			end_pos = {1'b0, position} + 17'd1;
			recent = {recent[55:0], item.data_byte};

			// The first pattern byte lines up with the oldest byte of the window.
			hit = 1'b1;
			for (int k = 0; k < len; k++) begin
				if (cfg_pattern[8*k +: 8] != recent[8*(len-1-k) +: 8])
					hit = 1'b0;
			end

			if (hit && end_pos >= 17'(len) && end_pos - 17'(len) >= {1'b0, seg_start}) begin
				if (seg_count != 16'hFFFF)
					seg_count = seg_count + 16'd1;
				seg.final_segment = 1'b0;
				if (cfg_limit != 16'd0 && seg_count == cfg_limit) begin
					stopped = 1'b1;
					seg.final_segment = 1'b1;
				end
				seg.segment_start  = seg_start;
				seg.segment_length = clamp16(end_pos - 17'(len) - {1'b0, seg_start});
				expected_segments = {expected_segments, seg};
				seg_start = clamp16(end_pos);
			end

			// The tail holds whatever follows the last delimiter, possibly nothing.
			if (item.end_of_message && !stopped) begin
				seg.segment_start  = seg_start;
				seg.segment_length = (end_pos >= {1'b0, seg_start}) ?
					clamp16(end_pos - {1'b0, seg_start}) : 16'd0;
				seg.final_segment  = 1'b1;
				expected_segments = {expected_segments, seg};
			end
			position = clamp16(end_pos);
		end
		if (item.end_of_message)
			clear_message();
	endtask

	// Compare one output transaction with the oldest prediction.
	task automatic compare_segment(input out_item_t got);
		out_item_t want;
		if (expected_segments.size() == 0) begin
			$error("unexpected segment: segment_start %0d, segment_length %0d, final_segment %0b",
				got.segment_start, got.segment_length, got.final_segment);
			fail_count++;
		end else begin
			want = expected_segments.pop_front();
			if (got.segment_start !== want.segment_start) begin
				$error("segment_start: expected %0d, actual %0d",
					want.segment_start, got.segment_start);
				fail_count++;
			end
			if (got.segment_length !== want.segment_length) begin
				$error("segment_length: expected %0d, actual %0d",
					want.segment_length, got.segment_length);
				fail_count++;
			end
			if (got.final_segment !== want.final_segment) begin
				$error("final_segment: expected %0b, actual %0b",
					want.final_segment, got.final_segment);
				fail_count++;
			end
		end
	endtask

	// Sample every channel at the clock edge, output first so that a stray
	// result cannot pair with a prediction made at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_pattern = '0;
			cfg_length  = 4'd1;
			cfg_limit   = '0;
			clear_message();
			expected_segments.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (out_valid && !out_stall)
				compare_segment(out_data);
			if (write_en) begin
				case (write_index)
					REG_DELIMITER_BYTES:  cfg_pattern = write_data;
					REG_DELIMITER_LENGTH: cfg_length  = write_data[3:0];
					REG_SEGMENT_LIMIT:    cfg_limit   = write_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_segments(in_data);
			pending = expected_segments.size();
		end
	end

endmodule

### dv/delimiter_stream_splitter_unit_tb.sv
// Testbench top of the delimiter stream splitter: clock, reset, byte stimulus and verdict.
// Depends on dss_pkg, delimiter_stream_splitter_unit and delimiter_stream_splitter_unit_checker.
`timescale 1ns / 100ps

module delimiter_stream_splitter_unit_tb;
	import dss_pkg::*;

	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 500;
	localparam int CALM_ITEMS     = 60;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	in_item_t    in_data     = '0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	out_item_t   out_data;
	logic        write_en    = 1'b0;
	logic [1:0]  write_index = REG_DELIMITER_BYTES;
	logic [63:0] write_data  = '0;

	int fail_count;
	int pending;
	int items_sent   = 0;
	int quiet_cycles = 0;
	int stall_left   = 0;
	bit no_gaps      = 1'b0;
	bit final_calm   = 1'b0;

	// Current delimiter as seen by the stimulus, used to shape messages.
	logic [63:0] cur_pattern = '0;
	int          cur_len     = 1;

	delimiter_stream_splitter_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.write_en    (write_en),
		.write_index (write_index),
		.write_data  (write_data)
	);

	delimiter_stream_splitter_unit_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.write_en    (write_en),
		.write_index (write_index),
		.write_data  (write_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always #5 clk = ~clk;

	// Output stalls come in random bursts unless gaps are off or the final calm has begun.
	always @(posedge clk) begin
		if (no_gaps || final_calm) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 4) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 3);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// The watchdog ends the run when no transaction moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Offer one byte and hold it until accepted, then maybe leave a gap.
	task automatic send_byte(input logic [7:0] value, input logic last);
		in_valid <= 1'b1;
		in_data  <= {value, last};
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
		if (!no_gaps && !final_calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Stop offering bytes and wait until every predicted segment has arrived.
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three registers on consecutive edges; unused high bits carry noise.
	task automatic configure(input logic [63:0] pattern, input logic [3:0] dlen,
		input logic [15:0] limit);
		logic [63:0] noise;
		noise = {$urandom, $urandom};
		write_en    <= 1'b1;
		write_index <= REG_DELIMITER_BYTES;
		write_data  <= pattern;
		@(posedge clk);
		write_index <= REG_DELIMITER_LENGTH;
		write_data  <= {noise[63:4], dlen};
		@(posedge clk);
		write_index <= REG_SEGMENT_LIMIT;
		write_data  <= {noise[63:16], limit};
		@(posedge clk);
		write_en    <= 1'b0;
		cur_pattern = pattern;
		cur_len     = (dlen == 4'd0) ? 1 : ((dlen > 4'd8) ? 8 : int'(dlen));
	endtask

	// A message built mostly from delimiter copies and delimiter bytes, or pure noise.
	task automatic send_message(input int count, input bit shaped);
		logic [7:0] body[$];
		int         pick;
		while (body.size() < count) begin
			pick = $urandom_range(0, 9);
			if (shaped && pick < 3) begin
				for (int k = 0; k < cur_len; k++)
					body = {body, cur_pattern[8*k +: 8]};
			end else if (shaped && pick < 7) begin
				body = {body, cur_pattern[8*$urandom_range(0, cur_len - 1) +: 8]};
			end else begin
				body = {body, 8'($urandom)};
			end
		end
		for (int k = 0; k < count; k++)
			send_byte(body[k], k == count - 1);
	endtask

	// One random setting of the registers followed by a few messages.
	task automatic random_phase();
		logic [63:0] pattern;
		logic [3:0]  dlen;
		logic [15:0] limit;
		logic [7:0]  fill;
		int          pick;
		fill = 8'($urandom);
		pick = $urandom_range(0, 9);
		if (pick == 0)
			pattern = '0;
		else if (pick == 1)
			pattern = '1;
		else if (pick == 2)
			pattern = {8{fill}};
		else
			pattern = {$urandom, $urandom};
		if ($urandom_range(0, 4) == 0)
			dlen = 4'($urandom_range(0, 15));
		else
			dlen = 4'($urandom_range(1, 8));
		pick = $urandom_range(0, 19);
		if (pick < 12)
			limit = 16'd0;
		else if (pick < 17)
			limit = 16'($urandom_range(1, 4));
		else if (pick == 17)
			limit = 16'hFFFF;
		else
			limit = 16'($urandom);
		no_gaps = ($urandom_range(0, 4) == 0);
		configure(pattern, dlen, limit);
		repeat ($urandom_range(1, 4))
			send_message($urandom_range(1, 24), $urandom_range(0, 4) != 0);
		wait_for_idle();
	endtask

	initial begin
		int goal;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset setting: single zero delimiter, which ends on the last byte.
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		wait_for_idle();

		// Two-byte delimiter, again ending on the last byte.
		configure(64'h4241, 4'd2, 16'd0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b0);
		send_byte(8'h79, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b1);
		wait_for_idle();

		// Repeated-byte delimiter: matches must not overlap.
		configure(64'h4141, 4'd2, 16'd0);
		repeat (4) send_byte(8'h41, 1'b0);
		send_byte(8'h41, 1'b1);
		wait_for_idle();

		// Limit of one: the first segment is final and the rest is dropped.
		configure(64'h4241, 4'd2, 16'd1);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b0);
		send_byte(8'h63, 1'b1);
		wait_for_idle();

		// Length zero acts as one; largest limit.
		configure(64'h0, 4'd0, 16'hFFFF);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		wait_for_idle();

		// Length above eight acts as eight; nothing matches before eight bytes.
		configure('1, 4'hF, 16'd0);
		repeat (7) send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		wait_for_idle();

		// Random settings and messages, then a calm tail.
		goal = items_sent + RANDOM_ITEMS - CALM_ITEMS;
		while (items_sent < goal)
			random_phase();
		final_calm = 1'b1;
		goal = items_sent + CALM_ITEMS;
		while (items_sent < goal)
			random_phase();

		wait_for_idle();
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
